// ----- design/bdll_pkg.sv -----
// Package for the bounded doubly linked list.
// Holds command and status codes, controller states and the ctl/datapath structs.
package bdll_pkg;

  localparam int unsigned DefCapacity = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned PosW = 7;
  localparam int unsigned CntW = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_REMOVE_AT  = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_READ_OUT   = 3'd6,
    CMD_UNUSED     = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_WALK_WAIT,
    S_RD_PREV,
    S_RD_WAIT,
    S_LINK1,
    S_LINK2,
    S_DROP_END,
    S_DROP_WAIT,
    S_DROP_FIN,
    S_EMIT,
    S_READ_REQ,
    S_READ_WAIT,
    S_READ_EMIT
  } state_e;

  // Operation the datapath carries out for one command step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ADD_FRONT,
    OP_ADD_BACK,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_RD_NODE,
    OP_MID_LINK1,
    OP_MID_LINK2,
    OP_DROP_RD,
    OP_DROP_FRONT,
    OP_DROP_BACK,
    OP_DROP_MID,
    OP_READ_RD,
    OP_READ_ADV
  } op_e;

  typedef struct packed {
    op_e     op;
    logic    emit;
    status_e status;
    logic    last;
    logic    use_elem;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic pos_zero;
    logic pos_eq_cnt;
    logic pos_eq_last;
    logic walk_done;
    logic read_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- design/bdll_if.sv -----
// Valid/ready channel interfaces for the list block.
// Depends on bdll_pkg for field widths.
interface bdll_in_if;
  logic                        valid;
  logic                        ready;
  logic [bdll_pkg::CmdW-1:0]   cmd;
  logic signed [bdll_pkg::ValueW-1:0] item_value;
  logic [bdll_pkg::PosW-1:0]   position;
  modport source (output valid, cmd, item_value, position, input ready);
  modport sink   (input valid, cmd, item_value, position, output ready);
endinterface

interface bdll_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdll_pkg::StatusW-1:0]  status;
  logic signed [bdll_pkg::ValueW-1:0] element;
  logic [bdll_pkg::CntW-1:0]     count;
  logic                          last;
  modport source (output valid, status, element, count, last, input ready);
  modport sink   (input valid, status, element, count, last, output ready);
endinterface

// ----- design/bounded_doubly_linked_list.sv -----
// Top level of the bounded doubly linked list (deque) block.
// Depends on bdll_pkg, bdll_if, bdll_ctrl and bdll_dp.
//
//   channel   dir   fields
//   in_if     in    cmd, item_value, position
//   out_if    out   status, element, count, last
//
// Push and error commands are answered from the decode state; pops read the
// end node and then unlink it. Remove at and insert at walk the links
// through the single node memory read port (one read plus one wait per node).
// Read out reads, waits for and emits each value. Reset clears head, tail, count and
// the free map at once. A stalled output holds the sequencer at the next result.
module bounded_doubly_linked_list #(
  parameter int unsigned CAPACITY = bdll_pkg::DefCapacity
) (
  input logic      clk_i,
  input logic      rst_ni,
  bdll_in_if.sink  in_if,
  bdll_out_if.source out_if
);
  import bdll_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bdll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  bdll_dp #(.Capacity(CAPACITY)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_cmd_i      (in_if.cmd),
    .in_value_i    (in_if.item_value),
    .in_pos_i      (in_if.position),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .out_valid_o   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_status_o  (out_if.status),
    .out_element_o (out_if.element),
    .out_count_o   (out_if.count),
    .out_last_o    (out_if.last)
  );

endmodule

// ----- design/bdll_ctrl.sv -----
// Command sequencer of the list block.
// Depends on bdll_pkg; drives the datapath through dp_cmd_t.
module bdll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bdll_pkg::dp_stat_t stat_i,
  output bdll_pkg::dp_cmd_t  cmd_o
);
  import bdll_pkg::*;

  state_e state_q, state_d;
  logic   mid_q, mid_d;  // walk serves an insert (0) or a remove (1)

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mid_q   <= mid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    mid_d        = mid_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.status = ST_OK;
    cmd_o.last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.out_busy) begin
          state_d    = S_IDLE;
          cmd_o.emit = 1'b1;
          case (stat_i.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (stat_i.full) cmd_o.status = ST_FULL;
              else cmd_o.op = (stat_i.cmd == CMD_PUSH_FRONT) ? OP_ADD_FRONT : OP_ADD_BACK;
            end
            CMD_INSERT_AT: begin
              if (stat_i.empty) cmd_o.status = ST_EMPTY;
              else if (stat_i.pos_gt_cnt) cmd_o.status = ST_RANGE;
              else if (stat_i.full) cmd_o.status = ST_FULL;
              else if (stat_i.pos_zero) cmd_o.op = OP_ADD_FRONT;
              else if (stat_i.pos_eq_cnt) cmd_o.op = OP_ADD_BACK;
              else begin
                cmd_o.emit = 1'b0;
                cmd_o.op   = OP_WALK_START;
                mid_d      = 1'b0;
                state_d    = S_WALK;
              end
            end
            CMD_REMOVE_AT: begin
              if (stat_i.empty) cmd_o.status = ST_EMPTY;
              else if (stat_i.pos_ge_cnt) cmd_o.status = ST_RANGE;
              else begin
                cmd_o.emit = 1'b0;
                cmd_o.op   = OP_WALK_START;
                mid_d      = 1'b1;
                state_d    = S_WALK;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (stat_i.empty) cmd_o.status = ST_EMPTY;
              else begin
                cmd_o.emit = 1'b0;
                cmd_o.op   = OP_DROP_RD;
                state_d    = S_DROP_WAIT;
              end
            end
            CMD_READ_OUT: begin
              if (stat_i.empty) cmd_o.status = ST_EMPTY;
              else begin
                cmd_o.emit = 1'b0;
                cmd_o.op   = OP_WALK_START;
                state_d    = S_READ_REQ;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          cmd_o.op = OP_RD_NODE;
          state_d  = S_RD_WAIT;
        end else begin
          cmd_o.op = OP_WALK_STEP;
          state_d  = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: state_d = S_WALK;
      S_RD_WAIT:   state_d = S_LINK1;
      S_LINK1: begin
        if (mid_q) begin
          if (!stat_i.out_busy) begin
            cmd_o.op       = OP_DROP_MID;
            cmd_o.emit     = 1'b1;
            cmd_o.use_elem = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_MID_LINK1;
          state_d  = S_LINK2;
        end
      end
      S_LINK2: begin
        if (!stat_i.out_busy) begin
          cmd_o.op   = OP_MID_LINK2;
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DROP_WAIT: state_d = S_DROP_FIN;
      S_DROP_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.op       = (stat_i.cmd == CMD_POP_BACK) ? OP_DROP_BACK : OP_DROP_FRONT;
          cmd_o.emit     = 1'b1;
          cmd_o.use_elem = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ_REQ: begin
        cmd_o.op = OP_READ_RD;
        state_d  = S_READ_WAIT;
      end
      S_READ_WAIT: state_d = S_READ_EMIT;
      S_READ_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op       = OP_READ_ADV;
          cmd_o.emit     = 1'b1;
          cmd_o.use_elem = 1'b1;
          cmd_o.last     = stat_i.read_last;
          state_d        = stat_i.read_last ? S_IDLE : S_READ_REQ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- design/bdll_dp.sv -----
// Datapath of the list block: node pool memories, head, tail, count, free map.
// Depends on bdll_pkg; steered by bdll_ctrl through dp_cmd_t.
module bdll_dp #(
  parameter int unsigned Capacity = bdll_pkg::DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [bdll_pkg::CmdW-1:0]         in_cmd_i,
  input  logic signed [bdll_pkg::ValueW-1:0] in_value_i,
  input  logic [bdll_pkg::PosW-1:0]         in_pos_i,
  input  bdll_pkg::dp_cmd_t                 cmd_i,
  output bdll_pkg::dp_stat_t                stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bdll_pkg::StatusW-1:0]      out_status_o,
  output logic signed [bdll_pkg::ValueW-1:0] out_element_o,
  output logic [bdll_pkg::CntW-1:0]         out_count_o,
  output logic                              out_last_o
);
  import bdll_pkg::*;

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic signed [ValueW-1:0] val_mem [Capacity];
  logic [IdxW-1:0]          nxt_mem [Capacity];
  logic [IdxW-1:0]          prv_mem [Capacity];

  logic [Capacity-1:0] free_q, free_d;
  logic [IdxW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  cmd_e                cmd_q;
  logic signed [ValueW-1:0] val_q;
  logic [PosW-1:0]     pos_q;
  logic [IdxW-1:0]     cur_q, cur_d;     // walk pointer
  logic [CntW-1:0]     step_q, step_d;   // walk/read index
  logic [IdxW-1:0]     pr_q;             // prev of the node at the index
  logic [IdxW-1:0]     new_q;            // node taken for a middle insert

  // read port results
  logic signed [ValueW-1:0] rd_val_q;
  logic [IdxW-1:0]          rd_nxt_q, rd_prv_q;
  logic [IdxW-1:0]          rd_addr;
  logic                     rd_en;

  // value write port and two link write ports (next, prev), used together in one step
  logic                     wv_en;
  logic [IdxW-1:0]          wv_addr;
  logic                     wn_en, wp_en;
  logic [IdxW-1:0]          wn_addr, wn_data, wp_addr, wp_data;

  logic                     ov_q;
  logic [StatusW-1:0]       os_q;
  logic signed [ValueW-1:0] oe_q;
  logic [CntW-1:0]          oc_q;
  logic                     ol_q;

  logic [IdxW-1:0] low_free;
  always_comb begin
    low_free = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (free_q[i]) low_free = IdxW'(i);
    end
  end

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.empty       = (cnt_q == '0);
    stat_o.full        = (cnt_q >= CntW'(Capacity));
    stat_o.pos_gt_cnt  = (pos_q > cnt_q);
    stat_o.pos_ge_cnt  = (pos_q >= cnt_q);
    stat_o.pos_zero    = (pos_q == '0);
    stat_o.pos_eq_cnt  = (pos_q == cnt_q);
    stat_o.pos_eq_last = (pos_q == cnt_q - CntW'(1));
    stat_o.walk_done   = (step_q == pos_q);
    stat_o.read_last   = (step_q + CntW'(1) == cnt_q);
    stat_o.out_busy    = ov_q && !out_ready_i;
  end

  always_comb begin
    free_d  = free_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    step_d  = step_q;
    rd_en   = 1'b0;
    rd_addr = cur_q;
    wv_en   = 1'b0;
    wv_addr = low_free;
    wn_en   = 1'b0; wn_addr = '0; wn_data = '0;
    wp_en   = 1'b0; wp_addr = '0; wp_data = '0;
    case (cmd_i.op)
      OP_ADD_FRONT: begin
        wv_en = 1'b1;
        free_d[low_free] = 1'b0;
        cnt_d = cnt_q + CntW'(1);
        head_d = low_free;
        if (cnt_q == '0) tail_d = low_free;
        else begin
          wn_en = 1'b1; wn_addr = low_free; wn_data = head_q;
          wp_en = 1'b1; wp_addr = head_q;   wp_data = low_free;
        end
      end
      OP_ADD_BACK: begin
        wv_en = 1'b1;
        free_d[low_free] = 1'b0;
        cnt_d = cnt_q + CntW'(1);
        tail_d = low_free;
        if (cnt_q == '0) head_d = low_free;
        else begin
          wp_en = 1'b1; wp_addr = low_free; wp_data = tail_q;
          wn_en = 1'b1; wn_addr = tail_q;   wn_data = low_free;
        end
      end
      OP_WALK_START: begin
        cur_d  = head_q;
        step_d = '0;
      end
      OP_WALK_STEP: begin
        rd_en  = 1'b1;
        step_d = step_q + CntW'(1);
      end
      OP_RD_NODE: rd_en = 1'b1;
      OP_MID_LINK1: begin
        wv_en = 1'b1;
        free_d[low_free] = 1'b0;
        cnt_d = cnt_q + CntW'(1);
        wn_en = 1'b1; wn_addr = low_free; wn_data = cur_q;
        wp_en = 1'b1; wp_addr = low_free; wp_data = rd_prv_q;
      end
      OP_MID_LINK2: begin
        wn_en = 1'b1; wn_addr = pr_q;  wn_data = new_q;
        wp_en = 1'b1; wp_addr = cur_q; wp_data = new_q;
      end
      OP_DROP_RD: begin
        rd_en   = 1'b1;
        rd_addr = (cmd_q == CMD_POP_BACK) ? tail_q : head_q;
      end
      OP_DROP_FRONT, OP_DROP_BACK, OP_DROP_MID: begin
        cnt_d = cnt_q - CntW'(1);
        if (cmd_i.op == OP_DROP_FRONT) begin
          free_d[head_q] = 1'b1;
          head_d = (cnt_q <= CntW'(1)) ? '0 : rd_nxt_q;
          if (cnt_q <= CntW'(1)) tail_d = '0;
        end else if (cmd_i.op == OP_DROP_BACK) begin
          free_d[tail_q] = 1'b1;
          tail_d = (cnt_q <= CntW'(1)) ? '0 : rd_prv_q;
          if (cnt_q <= CntW'(1)) head_d = '0;
        end else begin
          free_d[cur_q] = 1'b1;
          if (pos_q == '0) begin
            head_d = (cnt_q <= CntW'(1)) ? '0 : rd_nxt_q;
            if (cnt_q <= CntW'(1)) tail_d = '0;
          end else if (pos_q == cnt_q - CntW'(1)) begin
            tail_d = rd_prv_q;
          end else begin
            wn_en = 1'b1; wn_addr = rd_prv_q; wn_data = rd_nxt_q;
            wp_en = 1'b1; wp_addr = rd_nxt_q; wp_data = rd_prv_q;
          end
        end
      end
      OP_READ_RD: rd_en = 1'b1;
      OP_READ_ADV: begin
        cur_d  = rd_nxt_q;
        step_d = step_q + CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wv_en) val_mem[wv_addr] <= (cmd_i.op == OP_MID_LINK1) ? val_q : val_q;
    if (wn_en) nxt_mem[wn_addr] <= wn_data;
    if (wp_en) prv_mem[wp_addr] <= wp_data;
    if (rd_en) begin
      rd_val_q <= val_mem[rd_addr];
      rd_nxt_q <= nxt_mem[rd_addr];
      rd_prv_q <= prv_mem[rd_addr];
    end
  end

  // walk pointer follows the link just read
  logic walk_adv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q     <= '1;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      cur_q      <= '0;
      step_q     <= '0;
      walk_adv_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      free_q     <= free_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      step_q     <= step_d;
      walk_adv_q <= (cmd_i.op == OP_WALK_STEP);
      cur_q      <= walk_adv_q ? rd_nxt_q : cur_d;
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      cmd_q <= cmd_e'(in_cmd_i);
      val_q <= in_value_i;
      pos_q <= in_pos_i;
    end
    if (cmd_i.op == OP_MID_LINK1) begin
      pr_q  <= rd_prv_q;
      new_q <= low_free;
    end
    if (cmd_i.emit) begin
      os_q <= cmd_i.status;
      oe_q <= cmd_i.use_elem ? rd_val_q : '0;
      oc_q <= cnt_d;
      ol_q <= cmd_i.last;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_status_o  = os_q;
  assign out_element_o = oe_q;
  assign out_count_o   = oc_q;
  assign out_last_o    = ol_q;

endmodule

// ----- design/bdll_checker.sv -----
// Port-level checks for the list block, bound to the top level.
// Depends on bdll_pkg and the top-level port names.
module bdll_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdll_pkg::StatusW-1:0]  out_status,
  input logic signed [bdll_pkg::ValueW-1:0] out_element,
  input logic [bdll_pkg::CntW-1:0]     out_count,
  input logic                          out_last
);
  import bdll_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_last))
    else $error("stalled word changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != ST_OK |-> out_element == '0 && out_last)
    else $error("error word carries data");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_count <= CntW'(DefCapacity * 2))
    else $error("count out of range");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

endmodule

bind bounded_doubly_linked_list bdll_props u_bdll_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_status  (out_if.status),
  .out_element (out_if.element),
  .out_count   (out_if.count),
  .out_last    (out_if.last)
);
